// File: src/brd_pkg.sv
// Package for the bus region decoder: widths, sizes, codes and the request,
// result, configuration and queue entry types. No dependencies.
package brd_pkg;

  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned COUNT_W = 32;

  localparam int unsigned ROM_BYTES      = 524288;
  localparam int unsigned ROM_AW         = $clog2(ROM_BYTES);
  localparam int unsigned ROM_BANK_AW    = ROM_AW - 1;
  localparam int unsigned ROM_BANK_DEPTH = ROM_BYTES / 2;
  localparam logic [ADDR_W-1:0] ROM_DECODE_LAST = ADDR_W'(524287);
  localparam logic [ADDR_W:0]   ROM_END         = (ADDR_W + 1)'(ROM_BYTES);

  localparam int unsigned WRAM_BYTES      = 8192;
  localparam int unsigned WRAM_AW         = $clog2(WRAM_BYTES);
  localparam int unsigned WRAM_BANK_AW    = WRAM_AW - 1;
  localparam int unsigned WRAM_BANK_DEPTH = WRAM_BYTES / 2;
  localparam logic [ADDR_W-1:0] WRAM_SIZE = ADDR_W'(WRAM_BYTES);

  localparam int unsigned SHADOW_ENTRIES = 8;
  localparam int unsigned SHADOW_AW      = $clog2(SHADOW_ENTRIES);
  localparam int unsigned INPUT_PORTS    = 3;

  localparam int unsigned REGION_TOTAL  = 6;
  localparam int unsigned COUNTER_TOTAL = REGION_TOTAL * 4;
  localparam int unsigned CNT_IDX_W     = $clog2(COUNTER_TOTAL);

  localparam int unsigned REG_TOTAL = 8;
  localparam int unsigned REG_IDX_W = $clog2(REG_TOTAL);
  localparam int unsigned PADDR_W   = $clog2(REG_TOTAL * 4);

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0]        BYTE_ONES = 8'hFF;
  localparam logic [DATA_W-1:0] WORD_ONES = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_READ     = 2'd0,
    ACT_WRITE    = 2'd1,
    ACT_ROM_LOAD = 2'd2,
    ACT_PORT_SET = 2'd3
  } brd_action_e;

  typedef enum logic [2:0] {
    RG_ROM     = 3'd0,
    RG_WRAM    = 3'd1,
    RG_INPUT   = 3'd2,
    RG_VIDEO   = 3'd3,
    RG_SOUND   = 3'd4,
    RG_UNKNOWN = 3'd5
  } brd_region_e;

  typedef enum logic [1:0] {
    PORT_P0  = 2'd0,
    PORT_P1  = 2'd1,
    PORT_DIP = 2'd2
  } brd_port_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_WRAM_BASE   = 3'd0,
    REG_PORT0       = 3'd1,
    REG_PORT1       = 3'd2,
    REG_DIP         = 3'd3,
    REG_VIDEO_FIRST = 3'd4,
    REG_VIDEO_LAST  = 3'd5,
    REG_SOUND_FIRST = 3'd6,
    REG_SOUND_LAST  = 3'd7
  } brd_reg_e;

  typedef struct packed {
    logic [1:0]        action;
    logic              is_wide;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } brd_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [2:0]         region;
    logic [COUNT_W-1:0] access_count;
  } brd_out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] workram_base;
    logic [ADDR_W-1:0] port0_address;
    logic [ADDR_W-1:0] port1_address;
    logic [ADDR_W-1:0] dip_address;
    logic [ADDR_W-1:0] video_first;
    logic [ADDR_W-1:0] video_last;
    logic [ADDR_W-1:0] sound_first;
    logic [ADDR_W-1:0] sound_last;
  } brd_cfg_t;

  typedef struct packed {
    brd_action_e          action;
    logic                 wide;
    logic [ADDR_W-1:0]    address;
    logic [DATA_W-1:0]    wdata;
    brd_region_e          region;
    logic [WRAM_AW-1:0]   wram_off;
    logic [SHADOW_AW-1:0] shadow_idx;
    logic                 port_hit;
    brd_port_e            port_slot;
  } brd_item_t;

endpackage

// File: src/brd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/brd_front.sv
// Front end: accepts requests and classifies them into bus regions.
// Depends on brd_pkg.
module brd_front import brd_pkg::*; (
  input  logic      start_i,
  input  brd_in_t   req_i,
  input  brd_cfg_t  cfg_i,
  input  logic      q_full_i,
  input  logic      clearing_i,
  output logic      busy_o,
  output logic      push_o,
  output brd_item_t item_o
);

  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] wdiff;
  logic [ADDR_W-1:0] vdiff;
  logic [ADDR_W-1:0] sdiff;
  logic              hit_p0;
  logic              hit_p1;
  logic              hit_dip;
  brd_region_e       bus_region;
  brd_action_e       action;

  assign busy_o = q_full_i | clearing_i;
  assign push_o = start_i & ~busy_o;

  assign addr    = req_i.address;
  assign action  = brd_action_e'(req_i.action);
  assign wdiff   = addr - cfg_i.workram_base;
  assign vdiff   = addr - cfg_i.video_first;
  assign sdiff   = addr - cfg_i.sound_first;
  assign hit_p0  = addr == cfg_i.port0_address;
  assign hit_p1  = addr == cfg_i.port1_address;
  assign hit_dip = addr == cfg_i.dip_address;

  always_comb begin
    priority if (addr <= ROM_DECODE_LAST) begin
      bus_region = RG_ROM;
    end else if (addr >= cfg_i.workram_base && wdiff < WRAM_SIZE) begin
      bus_region = RG_WRAM;
    end else if (hit_p0 || hit_p1 || hit_dip) begin
      bus_region = RG_INPUT;
    end else if (addr >= cfg_i.video_first && addr <= cfg_i.video_last) begin
      bus_region = RG_VIDEO;
    end else if (addr >= cfg_i.sound_first && addr <= cfg_i.sound_last) begin
      bus_region = RG_SOUND;
    end else begin
      bus_region = RG_UNKNOWN;
    end
  end

  always_comb begin
    item_o.action   = action;
    item_o.wide     = req_i.is_wide;
    item_o.address  = addr;
    item_o.wdata    = req_i.write_data;
    item_o.wram_off = wdiff[WRAM_AW-1:0];
    item_o.port_hit = hit_p0 | hit_p1 | hit_dip;
    priority if (hit_p0) begin
      item_o.port_slot = PORT_P0;
    end else if (hit_p1) begin
      item_o.port_slot = PORT_P1;
    end else begin
      item_o.port_slot = PORT_DIP;
    end
    item_o.shadow_idx = (bus_region == RG_VIDEO) ? vdiff[SHADOW_AW:1] : sdiff[SHADOW_AW:1];
    unique case (action)
      ACT_ROM_LOAD: item_o.region = RG_ROM;
      ACT_PORT_SET: item_o.region = RG_INPUT;
      default:      item_o.region = bus_region;
    endcase
  end

endmodule

// File: src/brd_queue.sv
// Short queue of classified requests between the front and back ends.
// Depends on brd_pkg.
module brd_queue import brd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  brd_item_t item_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output brd_item_t item_o
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  brd_item_t        slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = count_q == CNT_FULL;
  assign valid_o = count_q != '0;
  assign item_o  = slot_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !do_pop |-> !push_i)
    else $error("request pushed into a full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue count beyond depth");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("request popped from an empty queue");
`endif

endmodule

// File: src/brd_back.sv
// Back end: carries out queued requests against ROM, work RAM, shadows and
// counters, and drives the result strobe. Depends on brd_pkg and brd_ram.
module brd_back import brd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  brd_item_t head_i,
  output logic      pop_o,
  output logic      clearing_o,
  output logic      done_o,
  output brd_out_t  rsp_o
);

  typedef enum logic [1:0] {
    ST_CLEAR = 2'b01,
    ST_RUN   = 2'b10
  } brd_state_e;

  brd_state_e              state_q, state_d;
  logic [WRAM_BANK_AW-1:0] clr_cnt_q;

  logic              is_read;
  logic              bus_wr;
  logic              is_load;
  logic [DATA_W-1:0] wval;

  logic [ADDR_W:0]        rom_a1;
  logic                   rom_oob0;
  logic                   rom_oob1;
  logic [ROM_BANK_AW-1:0] rom_even_raddr;
  logic [ROM_BANK_AW-1:0] rom_odd_raddr;
  logic [ROM_BANK_AW-1:0] rom_waddr;
  logic                   rom_we_even;
  logic                   rom_we_odd;
  logic [7:0]             rom_even_rd;
  logic [7:0]             rom_odd_rd;

  logic [WRAM_AW-1:0]      off;
  logic [WRAM_AW-1:0]      off2;
  logic [WRAM_BANK_AW-1:0] wram_even_idx;
  logic [WRAM_BANK_AW-1:0] wram_odd_idx;
  logic                    wram_wr;
  logic                    wram_we_even;
  logic                    wram_we_odd;
  logic [WRAM_BANK_AW-1:0] wram_waddr_even;
  logic [WRAM_BANK_AW-1:0] wram_waddr_odd;
  logic [7:0]              wram_wdata_even;
  logic [7:0]              wram_wdata_odd;
  logic [7:0]              wram_even_rd;
  logic [7:0]              wram_odd_rd;

  logic [DATA_W-1:0] input_sh_q [INPUT_PORTS];
  logic [DATA_W-1:0] video_sh_q [SHADOW_ENTRIES];
  logic [DATA_W-1:0] sound_sh_q [SHADOW_ENTRIES];
  logic [DATA_W-1:0] shadow_rd;

  logic [COUNT_W-1:0]   cnt_q [COUNTER_TOTAL];
  logic [COUNT_W-1:0]   cnt_next;
  logic [CNT_IDX_W-1:0] idx;

  logic                 rsp_valid_q;
  brd_action_e          rsp_action_q;
  brd_region_e          rsp_region_q;
  logic                 rsp_wide_q;
  logic                 rsp_odd_q;
  logic                 rsp_oob0_q;
  logic                 rsp_oob1_q;
  logic [DATA_W-1:0]    rsp_shadow_q;
  logic [CNT_IDX_W-1:0] rsp_idx_q;

  logic              rsp_is_bus;
  logic [7:0]        b_even;
  logic [7:0]        b_odd;
  logic [7:0]        b0;
  logic [7:0]        b1;
  logic [DATA_W-1:0] val;

  assign clearing_o = state_q == ST_CLEAR;
  assign pop_o      = head_valid_i & (state_q == ST_RUN);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (&clr_cnt_q) state_d = ST_RUN;
      ST_RUN:   state_d = ST_RUN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  assign is_read  = head_i.action == ACT_READ;
  assign bus_wr   = head_i.action == ACT_WRITE;
  assign is_load  = head_i.action == ACT_ROM_LOAD;
  assign wval     = head_i.wide ? head_i.wdata : {8'h00, head_i.wdata[7:0]};

  // ROM: two byte banks so a 16-bit read fetches both bytes at once
  assign rom_a1         = {1'b0, head_i.address} + 1'b1;
  assign rom_oob0       = {1'b0, head_i.address} >= ROM_END;
  assign rom_oob1       = rom_a1 >= ROM_END;
  assign rom_even_raddr = head_i.address[0] ? rom_a1[ROM_AW-1:1]
                                            : head_i.address[ROM_AW-1:1];
  assign rom_odd_raddr  = head_i.address[ROM_AW-1:1];
  assign rom_waddr      = head_i.address[ROM_AW-1:1];
  assign rom_we_even    = pop_o & is_load & ~rom_oob0 & ~head_i.address[0];
  assign rom_we_odd     = pop_o & is_load & ~rom_oob0 & head_i.address[0];

  brd_ram #(.WIDTH(8), .DEPTH(ROM_BANK_DEPTH)) u_rom_even (
    .clk_i   (clk_i),
    .we_i    (rom_we_even),
    .waddr_i (rom_waddr),
    .wdata_i (head_i.wdata[7:0]),
    .raddr_i (rom_even_raddr),
    .rdata_o (rom_even_rd)
  );

  brd_ram #(.WIDTH(8), .DEPTH(ROM_BANK_DEPTH)) u_rom_odd (
    .clk_i   (clk_i),
    .we_i    (rom_we_odd),
    .waddr_i (rom_waddr),
    .wdata_i (head_i.wdata[7:0]),
    .raddr_i (rom_odd_raddr),
    .rdata_o (rom_odd_rd)
  );

  // Work RAM: even and odd byte banks, the second byte wraps to the first
  assign off           = head_i.wram_off;
  assign off2          = off + 1'b1;
  assign wram_even_idx = off[0] ? off2[WRAM_AW-1:1] : off[WRAM_AW-1:1];
  assign wram_odd_idx  = off[WRAM_AW-1:1];
  assign wram_wr       = pop_o & bus_wr & (head_i.region == RG_WRAM);

  always_comb begin
    if (clearing_o) begin
      wram_we_even    = 1'b1;
      wram_we_odd     = 1'b1;
      wram_waddr_even = clr_cnt_q;
      wram_waddr_odd  = clr_cnt_q;
      wram_wdata_even = '0;
      wram_wdata_odd  = '0;
    end else begin
      wram_we_even    = wram_wr & (head_i.wide | ~off[0]);
      wram_we_odd     = wram_wr & (head_i.wide | off[0]);
      wram_waddr_even = wram_even_idx;
      wram_waddr_odd  = wram_odd_idx;
      if (head_i.wide) begin
        wram_wdata_even = off[0] ? head_i.wdata[7:0] : head_i.wdata[15:8];
        wram_wdata_odd  = off[0] ? head_i.wdata[15:8] : head_i.wdata[7:0];
      end else begin
        wram_wdata_even = head_i.wdata[7:0];
        wram_wdata_odd  = head_i.wdata[7:0];
      end
    end
  end

  brd_ram #(.WIDTH(8), .DEPTH(WRAM_BANK_DEPTH)) u_wram_even (
    .clk_i   (clk_i),
    .we_i    (wram_we_even),
    .waddr_i (wram_waddr_even),
    .wdata_i (wram_wdata_even),
    .raddr_i (wram_even_idx),
    .rdata_o (wram_even_rd)
  );

  brd_ram #(.WIDTH(8), .DEPTH(WRAM_BANK_DEPTH)) u_wram_odd (
    .clk_i   (clk_i),
    .we_i    (wram_we_odd),
    .waddr_i (wram_waddr_odd),
    .wdata_i (wram_wdata_odd),
    .raddr_i (wram_odd_idx),
    .rdata_o (wram_odd_rd)
  );

  always_comb begin
    unique case (head_i.region)
      RG_INPUT: begin
        unique case (head_i.port_slot)
          PORT_P0: shadow_rd = input_sh_q[0];
          PORT_P1: shadow_rd = input_sh_q[1];
          default: shadow_rd = input_sh_q[2];
        endcase
      end
      RG_VIDEO: shadow_rd = video_sh_q[head_i.shadow_idx];
      RG_SOUND: shadow_rd = sound_sh_q[head_i.shadow_idx];
      default:  shadow_rd = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < INPUT_PORTS; i++) begin
        input_sh_q[i] <= WORD_ONES;
      end
      for (int i = 0; i < SHADOW_ENTRIES; i++) begin
        video_sh_q[i] <= '0;
        sound_sh_q[i] <= '0;
      end
    end else if (pop_o) begin
      if (bus_wr) begin
        unique case (head_i.region)
          RG_VIDEO: video_sh_q[head_i.shadow_idx] <= wval;
          RG_SOUND: sound_sh_q[head_i.shadow_idx] <= wval;
          default: ;
        endcase
      end
      if (head_i.action == ACT_PORT_SET && head_i.port_hit) begin
        unique case (head_i.port_slot)
          PORT_P0: input_sh_q[0] <= head_i.wdata;
          PORT_P1: input_sh_q[1] <= head_i.wdata;
          default: input_sh_q[2] <= head_i.wdata;
        endcase
      end
    end
  end

  assign idx = {head_i.region, bus_wr, head_i.wide};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_action_q <= head_i.action;
      rsp_region_q <= head_i.region;
      rsp_wide_q   <= head_i.wide;
      rsp_odd_q    <= (head_i.region == RG_ROM) ? head_i.address[0] : off[0];
      rsp_oob0_q   <= rom_oob0;
      rsp_oob1_q   <= rom_oob1;
      rsp_shadow_q <= is_read ? shadow_rd : '0;
      rsp_idx_q    <= idx;
    end
  end

  assign rsp_is_bus = (rsp_action_q == ACT_READ) || (rsp_action_q == ACT_WRITE);
  assign cnt_next   = cnt_q[rsp_idx_q] + 1'b1;

  always_comb begin
    b_even = (rsp_region_q == RG_ROM) ? rom_even_rd : wram_even_rd;
    b_odd  = (rsp_region_q == RG_ROM) ? rom_odd_rd : wram_odd_rd;
    b0     = rsp_odd_q ? b_odd : b_even;
    b1     = rsp_odd_q ? b_even : b_odd;
    if (rsp_region_q == RG_ROM) begin
      if (rsp_oob0_q) b0 = BYTE_ONES;
      if (rsp_oob1_q) b1 = BYTE_ONES;
    end
    unique case (rsp_region_q)
      RG_ROM, RG_WRAM: begin
        val = rsp_wide_q ? {b0, b1} : {8'h00, b0};
      end
      RG_INPUT, RG_VIDEO, RG_SOUND: begin
        val = rsp_wide_q ? rsp_shadow_q : {8'h00, rsp_shadow_q[7:0]};
      end
      default: begin
        val = rsp_wide_q ? WORD_ONES : {8'h00, BYTE_ONES};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COUNTER_TOTAL; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (rsp_valid_q && rsp_is_bus) begin
      cnt_q[rsp_idx_q] <= cnt_next;
    end
  end

  assign done_o             = rsp_valid_q;
  assign rsp_o.read_data    = (rsp_action_q == ACT_READ) ? val : '0;
  assign rsp_o.region       = rsp_region_q;
  assign rsp_o.access_count = rsp_is_bus ? cnt_next : '0;

`ifndef SYNTHESIS
  a_counter_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_is_bus |=> cnt_q[$past(rsp_idx_q)] == $past(cnt_next))
    else $error("access counter did not advance by one");

  a_sweep_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_o) |-> &$past(clr_cnt_q))
    else $error("work RAM sweep ended early");

  a_idle_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_o |-> !head_valid_i && !rsp_valid_q)
    else $error("request queued during work RAM sweep");
`endif

endmodule

// File: src/bus_region_decoder_with_access_counters.sv
// Top level of the bus region decoder: APB configuration registers and the
// front end, queue and back end. Depends on brd_pkg, brd_front, brd_queue, brd_back.

// Takes one request per clock while busy is low; each result shows on rsp_o
// with done_o high for one cycle, after the request has passed through the
// queue slot and the registered response fields, and the receiver cannot
// stall it. The back end runs every queued request through ROM and work RAM
// byte-bank reads, registered with the response, and then the counter update,
// so it keeps up with one request per clock. After reset busy stays high
// while both work RAM banks are swept to zero, one row a cycle; configuration
// writes are taken meanwhile.
module bus_region_decoder_with_access_counters import brd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  brd_in_t            req_i,
  output logic               done_o,
  output brd_out_t           rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  brd_cfg_t  cfg_q;
  brd_reg_e  reg_idx;
  logic      q_full;
  logic      clearing;
  logic      push;
  brd_item_t push_item;
  logic      head_valid;
  brd_item_t head_item;
  logic      pop;

  assign pready  = 1'b1;
  assign reg_idx = brd_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.workram_base  <= ADDR_W'(24'h10C000);
      cfg_q.port0_address <= '0;
      cfg_q.port1_address <= '0;
      cfg_q.dip_address   <= '0;
      cfg_q.video_first   <= '0;
      cfg_q.video_last    <= '0;
      cfg_q.sound_first   <= '0;
      cfg_q.sound_last    <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_WRAM_BASE:   cfg_q.workram_base  <= pwdata[ADDR_W-1:0];
        REG_PORT0:       cfg_q.port0_address <= pwdata[ADDR_W-1:0];
        REG_PORT1:       cfg_q.port1_address <= pwdata[ADDR_W-1:0];
        REG_DIP:         cfg_q.dip_address   <= pwdata[ADDR_W-1:0];
        REG_VIDEO_FIRST: cfg_q.video_first   <= pwdata[ADDR_W-1:0];
        REG_VIDEO_LAST:  cfg_q.video_last    <= pwdata[ADDR_W-1:0];
        REG_SOUND_FIRST: cfg_q.sound_first   <= pwdata[ADDR_W-1:0];
        REG_SOUND_LAST:  cfg_q.sound_last    <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WRAM_BASE:   prdata = {8'h00, cfg_q.workram_base};
      REG_PORT0:       prdata = {8'h00, cfg_q.port0_address};
      REG_PORT1:       prdata = {8'h00, cfg_q.port1_address};
      REG_DIP:         prdata = {8'h00, cfg_q.dip_address};
      REG_VIDEO_FIRST: prdata = {8'h00, cfg_q.video_first};
      REG_VIDEO_LAST:  prdata = {8'h00, cfg_q.video_last};
      REG_SOUND_FIRST: prdata = {8'h00, cfg_q.sound_first};
      REG_SOUND_LAST:  prdata = {8'h00, cfg_q.sound_last};
      default:         prdata = '0;
    endcase
  end

  brd_front u_front (
    .start_i    (start),
    .req_i      (req_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .busy_o     (busy),
    .push_o     (push),
    .item_o     (push_item)
  );

  brd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (head_valid),
    .item_o  (head_item)
  );

  brd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_item),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .rsp_o        (rsp_o)
  );

endmodule

// File: tb/bus_region_decoder_with_access_counters_test.sv
// Self-checking testbench for bus_region_decoder_with_access_counters: drives
// bus requests and APB map settings, predicts every result, checks each strobe.
// Depends on brd_pkg and the RTL of the block only.
module bus_region_decoder_with_access_counters_test;
  import brd_pkg::*;

  localparam int unsigned CLK_HALF          = 5;
  localparam int unsigned STALL_LIMIT       = 20000;
  localparam int unsigned ITEMS_PER_SETTING = 190;
  localparam logic [ADDR_W-1:0] WRAM_BASE_RESET = 24'h10C000;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start;
  logic               busy;
  brd_in_t            req_i;
  logic               done_o;
  brd_out_t           rsp_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  logic [ADDR_W-1:0]  map_reg [REG_TOTAL];
  logic [7:0]         rom_mirror [int unsigned];
  int unsigned        rom_loaded_list [$];
  logic [7:0]         wram_mirror [WRAM_BYTES];
  logic [DATA_W-1:0]  port_value [INPUT_PORTS];
  logic [DATA_W-1:0]  video_bank [SHADOW_ENTRIES];
  logic [DATA_W-1:0]  sound_bank [SHADOW_ENTRIES];
  logic [COUNT_W-1:0] hit_count [COUNTER_TOTAL];

  brd_out_t    pending_results [$];
  brd_out_t    expected_result;
  int unsigned error_count;
  int unsigned requests_sent;
  int unsigned results_checked;
  int unsigned settings_applied;
  int unsigned stall_cycles;

  bus_region_decoder_with_access_counters dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  function automatic brd_region_e decode_region(logic [ADDR_W-1:0] a);
    if (a <= ROM_DECODE_LAST) return RG_ROM;
    if (a >= map_reg[REG_WRAM_BASE] && (a - map_reg[REG_WRAM_BASE]) < WRAM_SIZE) return RG_WRAM;
    if (a == map_reg[REG_PORT0] || a == map_reg[REG_PORT1] || a == map_reg[REG_DIP]) begin
      return RG_INPUT;
    end
    if (a >= map_reg[REG_VIDEO_FIRST] && a <= map_reg[REG_VIDEO_LAST]) return RG_VIDEO;
    if (a >= map_reg[REG_SOUND_FIRST] && a <= map_reg[REG_SOUND_LAST]) return RG_SOUND;
    return RG_UNKNOWN;
  endfunction

  function automatic logic [7:0] rom_byte(int unsigned a);
    if (a >= ROM_BYTES) return BYTE_ONES;
    if (rom_mirror.exists(a)) return rom_mirror[a];
    return 8'h00;
  endfunction

  function automatic bit rom_read_ok(logic [ADDR_W-1:0] a, logic wide);
    int unsigned next_a;
    next_a = int'(a) + 1;
    return rom_mirror.exists(a) && (!wide || next_a >= ROM_BYTES || rom_mirror.exists(next_a));
  endfunction

  function automatic brd_port_e port_slot(logic [ADDR_W-1:0] a);
    if (a == map_reg[REG_PORT0]) return PORT_P0;
    if (a == map_reg[REG_PORT1]) return PORT_P1;
    return PORT_DIP;
  endfunction

  function automatic logic [SHADOW_AW-1:0] shadow_slot(logic [ADDR_W-1:0] a,
                                                       logic [ADDR_W-1:0] lo);
    logic [ADDR_W-1:0] dist_a;
    dist_a = a - lo;
    return dist_a[SHADOW_AW:1];
  endfunction

  // Update the mirrored bus map with one request and return its result.
  function automatic brd_out_t predict_bus_access(brd_in_t r);
    brd_out_t          res;
    brd_region_e       rg;
    logic [ADDR_W-1:0] a;
    logic [WRAM_AW-1:0] off;
    logic [WRAM_AW-1:0] off2;
    logic [DATA_W-1:0] val;
    int unsigned       idx;
    a = r.address;
    res = '0;
    if (r.action == ACT_ROM_LOAD) begin
      if (a < ROM_BYTES) begin
        if (!rom_mirror.exists(a)) rom_loaded_list.push_back(a);
        rom_mirror[a] = r.write_data[7:0];
      end
      res.region = RG_ROM;
      return res;
    end
    if (r.action == ACT_PORT_SET) begin
      if (a == map_reg[REG_PORT0] || a == map_reg[REG_PORT1] || a == map_reg[REG_DIP]) begin
        port_value[port_slot(a)] = r.write_data;
      end
      res.region = RG_INPUT;
      return res;
    end
    rg = decode_region(a);
    off = WRAM_AW'(a - map_reg[REG_WRAM_BASE]);
    off2 = off + 1'b1;
    if (r.action == ACT_READ) begin
      case (rg)
        RG_ROM: val = r.is_wide ? {rom_byte(a), rom_byte(int'(a) + 1)} : {8'h00, rom_byte(a)};
        RG_WRAM: val = r.is_wide ? {wram_mirror[off], wram_mirror[off2]}
                                 : {8'h00, wram_mirror[off]};
        RG_INPUT: val = port_value[port_slot(a)];
        RG_VIDEO: val = video_bank[shadow_slot(a, map_reg[REG_VIDEO_FIRST])];
        RG_SOUND: val = sound_bank[shadow_slot(a, map_reg[REG_SOUND_FIRST])];
        default: val = WORD_ONES;
      endcase
      if (!r.is_wide) val = {8'h00, val[7:0]};
      res.read_data = val;
    end else begin
      val = r.is_wide ? r.write_data : {8'h00, r.write_data[7:0]};
      case (rg)
        RG_WRAM: begin
          if (r.is_wide) begin
            wram_mirror[off] = val[15:8];
            wram_mirror[off2] = val[7:0];
          end else begin
            wram_mirror[off] = val[7:0];
          end
        end
        RG_VIDEO: video_bank[shadow_slot(a, map_reg[REG_VIDEO_FIRST])] = val;
        RG_SOUND: sound_bank[shadow_slot(a, map_reg[REG_SOUND_FIRST])] = val;
        default: ;
      endcase
    end
    idx = int'(rg) * 4 + ((r.action == ACT_WRITE) ? 2 : 0) + (r.is_wide ? 1 : 0);
    hit_count[idx] = hit_count[idx] + 1'b1;
    res.region = rg;
    res.access_count = hit_count[idx];
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] port_address();
    case ($urandom_range(0, 2))
      0: return map_reg[REG_PORT0];
      1: return map_reg[REG_PORT1];
      default: return map_reg[REG_DIP];
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] window_pick(logic [ADDR_W-1:0] lo,
                                                    logic [ADDR_W-1:0] hi);
    logic [ADDR_W-1:0] span;
    span = hi - lo;
    if (lo > hi) return lo;
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      2: return lo + ADDR_W'($urandom_range(0, (span < 64) ? span : 63));
      default: return lo + ADDR_W'($urandom % (32'(span) + 32'd1));
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] window_last(logic [ADDR_W-1:0] lo);
    case ($urandom_range(0, 3))
      0: return lo - 1'b1;
      1: return ADDR_W'($urandom);
      default: return lo + ADDR_W'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic brd_cfg_t random_map();
    brd_cfg_t c;
    c.workram_base = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                                 : ADDR_W'($urandom_range(ROM_BYTES, 24'hFFE000));
    c.port0_address = ADDR_W'($urandom_range(ROM_BYTES, 24'hFFFFFF));
    c.port1_address = ($urandom_range(0, 3) == 0) ? c.port0_address
                                                  : ADDR_W'($urandom_range(ROM_BYTES, 24'hFFFFFF));
    c.dip_address = ($urandom_range(0, 3) == 0) ? c.port1_address
                                                : ADDR_W'($urandom_range(ROM_BYTES, 24'hFFFFFF));
    c.video_first = ADDR_W'($urandom_range(ROM_BYTES, 24'hFFFFFF));
    c.video_last = window_last(c.video_first);
    c.sound_first = ($urandom_range(0, 1) == 0) ? c.video_first + ADDR_W'($urandom_range(0, 31))
                                                : ADDR_W'($urandom_range(ROM_BYTES, 24'hFFFFFF));
    c.sound_last = window_last(c.sound_first);
    return c;
  endfunction

  function automatic brd_in_t random_request();
    brd_in_t           r;
    int unsigned       pick;
    logic [ADDR_W-1:0] off;
    r.is_wide = 1'($urandom);
    r.write_data = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) r.action = ACT_READ;
    else if (pick < 75) r.action = ACT_WRITE;
    else if (pick < 87) r.action = ACT_ROM_LOAD;
    else r.action = ACT_PORT_SET;
    case (r.action)
      ACT_ROM_LOAD: begin
        case ($urandom_range(0, 3))
          0: r.address = ADDR_W'($urandom_range(0, 255));
          1: r.address = ADDR_W'(ROM_BYTES - 1 - $urandom_range(0, 255));
          2: r.address = ADDR_W'($urandom_range(0, ROM_BYTES - 1));
          default: r.address = ADDR_W'($urandom);
        endcase
      end
      ACT_PORT_SET: r.address = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom) : port_address();
      default: begin
        case ($urandom_range(0, 9))
          0: r.address = ADDR_W'(rom_loaded_list[$urandom_range(0, rom_loaded_list.size() - 1)]);
          1: r.address = ADDR_W'($urandom_range(0, ROM_DECODE_LAST));
          2, 3: begin
            case ($urandom_range(0, 2))
              0: off = '0;
              1: off = WRAM_SIZE - 1'b1;
              default: off = ADDR_W'($urandom_range(0, WRAM_BYTES - 1));
            endcase
            r.address = map_reg[REG_WRAM_BASE] + off;
          end
          4: r.address = port_address();
          5, 6: r.address = window_pick(map_reg[REG_VIDEO_FIRST], map_reg[REG_VIDEO_LAST]);
          7: r.address = window_pick(map_reg[REG_SOUND_FIRST], map_reg[REG_SOUND_LAST]);
          8: r.address = ADDR_W'($urandom);
          default: r.address = ($urandom_range(0, 1) == 0) ? 24'hFFFFFF : ROM_DECODE_LAST + 1'b1;
        endcase
      end
    endcase
    // steer reads away from ROM bytes that were never loaded
    if (r.action == ACT_READ && decode_region(r.address) == RG_ROM &&
        !rom_read_ok(r.address, r.is_wide)) begin
      r.address = ADDR_W'(rom_loaded_list[$urandom_range(0, rom_loaded_list.size() - 1)]);
      if (!rom_read_ok(r.address, r.is_wide)) r.is_wide = 1'b0;
    end
    return r;
  endfunction

  function automatic brd_in_t make_request(brd_action_e act, logic wide,
                                           logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    brd_in_t r;
    r.action = act;
    r.is_wide = wide;
    r.address = a;
    r.write_data = d;
    return r;
  endfunction

  task automatic issue_request(input brd_in_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(predict_bus_access(r));
    requests_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_register(input brd_reg_e idx, input logic [ADDR_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= {8'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    map_reg[idx] = value;
  endtask

  task automatic check_register(input brd_reg_e idx);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_W'(4 * int'(idx));
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (prdata[ADDR_W-1:0] !== map_reg[idx]) begin
      $error("register %0d: expected %h, got %h", int'(idx), map_reg[idx], prdata[ADDR_W-1:0]);
      error_count++;
    end
  endtask

  task automatic release_bus();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic program_map(input brd_cfg_t c);
    for (int i = 0; i < REG_TOTAL; i++) begin
      write_register(brd_reg_e'(i), c[(REG_TOTAL - 1 - i) * ADDR_W +: ADDR_W]);
    end
    for (int i = 0; i < REG_TOTAL; i++) check_register(brd_reg_e'(i));
    release_bus();
    settings_applied++;
  endtask

  task automatic apply_reset();
    start = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    foreach (map_reg[i]) map_reg[i] = '0;
    map_reg[REG_WRAM_BASE] = WRAM_BASE_RESET;
    foreach (wram_mirror[i]) wram_mirror[i] = 8'h00;
    foreach (port_value[i]) port_value[i] = WORD_ONES;
    foreach (video_bank[i]) video_bank[i] = '0;
    foreach (sound_bank[i]) sound_bank[i] = '0;
    foreach (hit_count[i]) hit_count[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic test_register_reset_values();
    for (int i = 0; i < REG_TOTAL; i++) check_register(brd_reg_e'(i));
    release_bus();
  endtask

  task automatic test_reset_map_requests();
    issue_request(make_request(ACT_ROM_LOAD, 1'b0, 24'h000000, 16'hA512));
    issue_request(make_request(ACT_ROM_LOAD, 1'b1, 24'h000001, 16'h0034));
    issue_request(make_request(ACT_ROM_LOAD, 1'b0, ROM_DECODE_LAST - 1'b1, 16'h7756));
    issue_request(make_request(ACT_ROM_LOAD, 1'b0, ROM_DECODE_LAST, 16'hFFFF));
    issue_request(make_request(ACT_ROM_LOAD, 1'b0, ROM_DECODE_LAST + 1'b1, 16'h0000));
    issue_request(make_request(ACT_ROM_LOAD, 1'b1, 24'hFFFFFF, 16'h00C3));
    issue_request(make_request(ACT_READ, 1'b0, 24'h000000, 16'h0000));
    issue_request(make_request(ACT_READ, 1'b1, 24'h000000, 16'hFFFF));
    issue_request(make_request(ACT_READ, 1'b1, ROM_DECODE_LAST - 1'b1, 16'h0000));
    issue_request(make_request(ACT_READ, 1'b1, ROM_DECODE_LAST, 16'h0000));
    issue_request(make_request(ACT_WRITE, 1'b1, 24'h000000, 16'hFFFF));
    issue_request(make_request(ACT_READ, 1'b1, WRAM_BASE_RESET, 16'h0000));
    issue_request(make_request(ACT_WRITE, 1'b1, WRAM_BASE_RESET + WRAM_SIZE - 1'b1, 16'hBEEF));
    issue_request(make_request(ACT_READ, 1'b1, WRAM_BASE_RESET, 16'h0000));
    issue_request(make_request(ACT_READ, 1'b1, WRAM_BASE_RESET + WRAM_SIZE - 1'b1, 16'h0000));
    issue_request(make_request(ACT_WRITE, 1'b0, WRAM_BASE_RESET + 1'b1, 16'h1234));
    issue_request(make_request(ACT_READ, 1'b0, 24'hFFFFFF, 16'h0000));
    issue_request(make_request(ACT_READ, 1'b1, 24'h800000, 16'h0000));
    issue_request(make_request(ACT_WRITE, 1'b0, 24'hFFFFFF, 16'h5555));
    issue_request(make_request(ACT_PORT_SET, 1'b0, 24'h000000, 16'h5A5A));
    issue_request(make_request(ACT_PORT_SET, 1'b1, 24'h123456, 16'hAAAA));
    drain_results();
  endtask

  task automatic test_window_special_cases();
    brd_cfg_t c;
    c.workram_base  = 24'h200000;
    c.port0_address = 24'h300000;
    c.port1_address = 24'h300000;
    c.dip_address   = 24'h300002;
    c.video_first   = 24'h400000;
    c.video_last    = 24'h40001F;
    c.sound_first   = 24'h400010;
    c.sound_last    = 24'h50000F;
    program_map(c);
    issue_request(make_request(ACT_PORT_SET, 1'b0, 24'h300000, 16'h1111));
    issue_request(make_request(ACT_READ, 1'b1, 24'h300000, 16'h0000));
    issue_request(make_request(ACT_PORT_SET, 1'b1, 24'h300002, 16'h2233));
    issue_request(make_request(ACT_READ, 1'b0, 24'h300002, 16'h0000));
    issue_request(make_request(ACT_WRITE, 1'b0, 24'h400013, 16'hABCD));
    issue_request(make_request(ACT_READ, 1'b1, 24'h400002, 16'h0000));
    issue_request(make_request(ACT_WRITE, 1'b1, 24'h50000F, 16'h9876));
    issue_request(make_request(ACT_READ, 1'b1, 24'h400010, 16'h0000));
    issue_request(make_request(ACT_READ, 1'b1, 24'h40002E, 16'h0000));
    drain_results();
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input brd_cfg_t c);
    program_map(c);
    for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
      while ($urandom_range(0, 99) < idle_pct) pause_sender(1);
      issue_request(random_request());
    end
    drain_results();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: read_data %h region %0d access_count %0d",
               rsp_o.read_data, rsp_o.region, rsp_o.access_count);
        error_count++;
      end else begin
        expected_result = pending_results.pop_front();
        results_checked++;
        if (rsp_o.read_data !== expected_result.read_data) begin
          $error("read_data: expected %h, got %h", expected_result.read_data, rsp_o.read_data);
          error_count++;
        end
        if (rsp_o.region !== expected_result.region) begin
          $error("region: expected %0d, got %0d", expected_result.region, rsp_o.region);
          error_count++;
        end
        if (rsp_o.access_count !== expected_result.access_count) begin
          $error("access_count: expected %0d, got %0d",
                 expected_result.access_count, rsp_o.access_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start === 1'b1 && busy === 1'b0) || done_o === 1'b1) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles > STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    requests_sent = 0;
    results_checked = 0;
    settings_applied = 0;
    stall_cycles = 0;
    apply_reset();
    test_register_reset_values();
    test_reset_map_requests();
    test_window_special_cases();
    test_random_traffic(18, '0);
    test_random_traffic(18, random_map());
    test_random_traffic(79, '1);
    test_random_traffic(79, random_map());
    test_random_traffic(0, random_map());
    test_random_traffic(0, random_map());
    repeat (4) @(posedge clk_i);
    $display("Covered %0d requests (reads, writes, ROM loads, port sets) over %0d bus map settings",
             requests_sent, settings_applied);
    $display("Compared %0d results, %0d mismatches", results_checked, error_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: bus_region_decoder_with_access_counters.f
src/brd_pkg.sv
src/brd_ram.sv
src/brd_front.sv
src/brd_queue.sv
src/brd_back.sv
src/bus_region_decoder_with_access_counters.sv
tb/bus_region_decoder_with_access_counters_test.sv
